[design/rpp_pkg.sv]
// Shared types and constants for the ring profile peak prominence unit.
`timescale 1ns / 1ps
package rpp_pkg;

  localparam int MAX_RINGS_DEF = 32;
  localparam int MEAN_BITS_DEF = 16;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MAX  = 2'd1;
  localparam logic [1:0] KIND_MIN  = 2'd2;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ADDR_I   = 3'd0,
    ADDR_P   = 3'd1,
    ADDR_PM1 = 3'd2,
    ADDR_Q   = 3'd3,
    ADDR_QP1 = 3'd4
  } addr_sel_t;

  typedef enum logic [13:0] {
    ST_LOAD  = 14'b00000000000001,
    ST_SC_RD = 14'b00000000000010,
    ST_SC_EV = 14'b00000000000100,
    ST_LP_RD = 14'b00000000001000,
    ST_LP_EV = 14'b00000000010000,
    ST_LL_RD = 14'b00000000100000,
    ST_LL_EV = 14'b00000001000000,
    ST_RP_RD = 14'b00000010000000,
    ST_RP_EV = 14'b00000100000000,
    ST_RL_RD = 14'b00001000000000,
    ST_RL_EV = 14'b00010000000000,
    ST_SCORE = 14'b00100000000000,
    ST_OUT_RD = 14'b01000000000000,
    ST_OUT_EV = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic      load_en;
    logic      scan_init;
    logic      scan_ev;
    logic      lp_ev;
    logic      ll_ev;
    logic      rp_ev;
    logic      rl_ev;
    logic      score;
    logic      out_ld;
    logic      clear;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic turn;
    logic i_lt_n;
    logic i1_lt_n;
    logic plat_l;
    logic p_zero;
    logic leg_l;
    logic p_one;
    logic plat_r;
    logic q_end;
    logic leg_r;
    logic q_end1;
    logic out_free;
    logic k_last;
  } sts_t;

endpackage

[design/rpp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rpp_ctrl.sv]
// Sequencer for load, scan, leg walks, scoring and result output.
`timescale 1ns / 1ps
module rpp_ctrl
  import rpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  input  logic last_sample,
  output logic sample_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = ADDR_I;
    sample_stall = 1'b1;
    case (state)
      ST_LOAD: begin
        sample_stall  = 1'b0;
        cmd.load_en   = sample_valid;
        cmd.scan_init = sample_valid && last_sample;
        if (sample_valid && last_sample) state_next = ST_SC_RD;
      end
      ST_SC_RD: begin
        cmd.addr_sel = ADDR_I;
        state_next   = ST_SC_EV;
      end
      ST_SC_EV: begin
        cmd.scan_ev = 1'b1;
        if (sts.turn) state_next = ST_LP_RD;
        else if (sts.i1_lt_n) state_next = ST_SC_RD;
        else state_next = ST_OUT_RD;
      end
      ST_LP_RD: begin
        cmd.addr_sel = ADDR_P;
        state_next   = ST_LP_EV;
      end
      ST_LP_EV: begin
        cmd.lp_ev = 1'b1;
        if (sts.plat_l) state_next = ST_LP_RD;
        else if (sts.p_zero) state_next = ST_RP_RD;
        else state_next = ST_LL_RD;
      end
      ST_LL_RD: begin
        cmd.addr_sel = ADDR_PM1;
        state_next   = ST_LL_EV;
      end
      ST_LL_EV: begin
        cmd.ll_ev = 1'b1;
        if (sts.leg_l && !sts.p_one) state_next = ST_LL_RD;
        else state_next = ST_RP_RD;
      end
      ST_RP_RD: begin
        cmd.addr_sel = ADDR_Q;
        state_next   = ST_RP_EV;
      end
      ST_RP_EV: begin
        cmd.rp_ev = 1'b1;
        if (sts.plat_r) state_next = ST_RP_RD;
        else if (sts.q_end) state_next = ST_SCORE;
        else state_next = ST_RL_RD;
      end
      ST_RL_RD: begin
        cmd.addr_sel = ADDR_QP1;
        state_next   = ST_RL_EV;
      end
      ST_RL_EV: begin
        cmd.rl_ev = 1'b1;
        if (sts.leg_r && !sts.q_end1) state_next = ST_RL_RD;
        else state_next = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.score  = 1'b1;
        state_next = sts.i_lt_n ? ST_SC_RD : ST_OUT_RD;
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_EV;
      end
      ST_OUT_EV: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          if (sts.k_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

[design/rpp_dp.sv]
// Datapath: profile and score stores, scan and walk registers, best tracking, output register.
`timescale 1ns / 1ps
module rpp_dp
  import rpp_pkg::*;
#(
  parameter int MAX_RINGS = MAX_RINGS_DEF,
  parameter int MEAN_BITS = MEAN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic [MEAN_BITS-1:0]         ring_mean,
  input  logic                         skip_ring,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [$clog2(MAX_RINGS)-1:0] ring_index,
  output logic [MEAN_BITS:0]           ring_score,
  output logic [1:0]                   extremum_kind,
  output logic [MEAN_BITS:0]           best_score,
  output logic [$clog2(MAX_RINGS)-1:0] best_ring,
  output logic                         best_found,
  output logic                         last_result
);

  localparam int IDX_W = $clog2(MAX_RINGS);
  localparam int CNT_W = $clog2(MAX_RINGS + 1);
  localparam int SC_W  = MEAN_BITS + 1;

  logic [CNT_W-1:0]     count, i, k;
  logic [IDX_W-1:0]     c, p, q, best_index;
  logic [MEAN_BITS-1:0] prev, v, le, re;
  logic                 prev_ok, is_max;
  dir_t                 dir;
  logic [SC_W-1:0]      best_value;
  logic [MAX_RINGS-1:0] sc_vld;

  logic [MEAN_BITS:0]   mean_rd;
  logic [MEAN_BITS-1:0] d_mean;
  logic                 d_ign;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [SC_W+1:0]      sc_rd;
  logic [CNT_W-1:0]     count_m1;
  logic [MEAN_BITS-1:0] ha, hb;
  logic [SC_W-1:0]      s;
  logic                 up, down;

  assign d_mean   = mean_rd[MEAN_BITS-1:0];
  assign d_ign    = mean_rd[MEAN_BITS];
  assign count_m1 = count - CNT_W'(1);
  assign mem_we   = cmd.load_en && (count < CNT_W'(MAX_RINGS));
  assign up       = d_mean > prev;
  assign down     = d_mean < prev;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_I:   raddr = i[IDX_W-1:0];
      ADDR_P:   raddr = p;
      ADDR_PM1: raddr = p - IDX_W'(1);
      ADDR_Q:   raddr = q;
      ADDR_QP1: raddr = q + IDX_W'(1);
      default:  raddr = i[IDX_W-1:0];
    endcase
  end

  rpp_ram #(.WIDTH(MEAN_BITS + 1), .DEPTH(MAX_RINGS)) u_mean_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({skip_ring, ring_mean}),
    .raddr (raddr),
    .rdata (mean_rd)
  );

  rpp_ram #(.WIDTH(SC_W + 2), .DEPTH(MAX_RINGS)) u_score_ram (
    .clk   (clk),
    .we    (cmd.score),
    .waddr (c),
    .wdata ({(is_max ? KIND_MAX : KIND_MIN), s}),
    .raddr (k[IDX_W-1:0]),
    .rdata (sc_rd)
  );

  // tent score: both leg heights, unhalved
  always_comb begin
    if (is_max) begin
      ha = (v > le) ? v - le : '0;
      hb = (v > re) ? v - re : '0;
    end else begin
      ha = (le > v) ? le - v : '0;
      hb = (re > v) ? re - v : '0;
    end
    s = {1'b0, ha} + {1'b0, hb};
  end

  always_comb begin
    sts.turn     = !d_ign && prev_ok && ((up && dir == DIR_FALL) || (down && dir == DIR_RISE));
    sts.i_lt_n   = i < count;
    sts.i1_lt_n  = (i + CNT_W'(1)) < count;
    sts.p_zero   = p == '0;
    sts.p_one    = p == IDX_W'(1);
    sts.plat_l   = !sts.p_zero && !d_ign && d_mean == v;
    sts.leg_l    = !d_ign && (is_max ? (d_mean < le) : (d_mean > le));
    sts.q_end    = CNT_W'(q) == count_m1;
    sts.q_end1   = (CNT_W'(q) + CNT_W'(1)) == count_m1;
    sts.plat_r   = !sts.q_end && !d_ign && d_mean == v;
    sts.leg_r    = !d_ign && (is_max ? (d_mean < re) : (d_mean > re));
    sts.out_free = !result_valid || !result_stall;
    sts.k_last   = k == count_m1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      k            <= '0;
      best_value   <= '0;
      best_index   <= '0;
      sc_vld       <= '0;
      prev_ok      <= 1'b0;
      dir          <= DIR_NONE;
      result_valid <= 1'b0;
    end else begin
      if (mem_we) count <= count + CNT_W'(1);
      if (cmd.scan_init) begin
        i       <= '0;
        prev_ok <= 1'b0;
        dir     <= DIR_NONE;
      end
      if (cmd.scan_ev) begin
        i <= i + CNT_W'(1);
        if (d_ign) begin
          dir     <= DIR_NONE;
          prev_ok <= 1'b0;
        end else begin
          if (prev_ok) begin
            if (up) dir <= DIR_RISE;
            else if (down) dir <= DIR_FALL;
          end
          prev    <= d_mean;
          prev_ok <= 1'b1;
        end
        if (sts.turn) begin
          c      <= IDX_W'(i - CNT_W'(1));
          p      <= IDX_W'(i - CNT_W'(2));
          q      <= i[IDX_W-1:0];
          v      <= prev;
          is_max <= down;
        end
      end
      if (cmd.lp_ev) begin
        if (sts.plat_l) p <= p - IDX_W'(1);
        else le <= d_mean;
      end
      if (cmd.ll_ev && sts.leg_l) begin
        p  <= p - IDX_W'(1);
        le <= d_mean;
      end
      if (cmd.rp_ev) begin
        if (sts.plat_r) q <= q + IDX_W'(1);
        else re <= d_mean;
      end
      if (cmd.rl_ev && sts.leg_r) begin
        q  <= q + IDX_W'(1);
        re <= d_mean;
      end
      if (cmd.score) begin
        sc_vld[c] <= 1'b1;
        if (s > best_value) begin
          best_value <= s;
          best_index <= c;
        end
      end
      if (cmd.out_ld) begin
        result_valid <= 1'b1;
        k            <= cmd.clear ? '0 : k + CNT_W'(1);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.clear) begin
        count      <= '0;
        best_value <= '0;
        best_index <= '0;
        sc_vld     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      ring_index    <= k[IDX_W-1:0];
      ring_score    <= sc_vld[k[IDX_W-1:0]] ? sc_rd[SC_W-1:0] : '0;
      extremum_kind <= sc_vld[k[IDX_W-1:0]] ? sc_rd[SC_W+1:SC_W] : KIND_NONE;
      best_score    <= best_value;
      best_ring     <= best_index;
      best_found    <= best_value != '0;
      last_result   <= sts.k_last;
    end
  end

endmodule

[design/ring_profile_peak_prominence_unit.sv]
// Top level of the ring profile peak prominence unit.
// Loading: one sample item per cycle, no result until the item with last_sample.
// Scoring: each scanned ring is read, then evaluated; a turn point adds a read and an evaluate
//   step per mean read of its walks (plateau, leg and leg-ending reads) and a score write.
// Output: after the scan, each result item is read from the score store, then sent when free.
// Reset (synchronous, active high): empty profile, scores and best cleared, no result.
`timescale 1ns / 1ps
module ring_profile_peak_prominence_unit
  import rpp_pkg::*;
#(
  parameter int MAX_RINGS = MAX_RINGS_DEF,
  parameter int MEAN_BITS = MEAN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [MEAN_BITS-1:0]         ring_mean,
  input  logic                         skip_ring,
  input  logic                         last_sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [$clog2(MAX_RINGS)-1:0] ring_index,
  output logic [MEAN_BITS:0]           ring_score,
  output logic [1:0]                   extremum_kind,
  output logic [MEAN_BITS:0]           best_score,
  output logic [$clog2(MAX_RINGS)-1:0] best_ring,
  output logic                         best_found,
  output logic                         last_result
);

  // controller decides the step, datapath holds all values
  cmd_t cmd;
  sts_t sts;

  rpp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_sample  (last_sample),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // mean store, score store with per-ring valid bits, turn walk registers
  rpp_dp #(.MAX_RINGS(MAX_RINGS), .MEAN_BITS(MEAN_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .ring_mean     (ring_mean),
    .skip_ring     (skip_ring),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .ring_index    (ring_index),
    .ring_score    (ring_score),
    .extremum_kind (extremum_kind),
    .best_score    (best_score),
    .best_ring     (best_ring),
    .best_found    (best_found),
    .last_result   (last_result)
  );

  // the last sample ends loading: no item is taken while the profile is scored
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && last_sample) |=> sample_stall)
    else $error("sample taken right after last sample");

  // scoring never overlaps loading
  a_score_not_load: assert property (@(posedge clk) disable iff (rst)
    cmd.score |-> sample_stall)
    else $error("score written while loading");

  // a stalled result item holds its place and payload
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(ring_index) && $stable(ring_score)))
    else $error("stalled result changed");

endmodule
